FILE: rtl/lr3_pkg.sv
// Package for the 3D line rasteriser: coordinate widths, word types for the
// command and point channels, the driving-axis code and the line state record.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lr3_pkg;

    localparam int COORD_BITS = 12;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic   kind;
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } cmd_word_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   last_point;
        logic   idle;
    } pnt_word_t;

    // Step sign bits: bit 0 x, bit 1 y, bit 2 z; a set bit steps negative.
    typedef struct packed {
        coord_t     cur_x;
        coord_t     cur_y;
        coord_t     cur_z;
        coord_t     drive_end;
        delta_t     delta_major;
        delta_t     delta_minor_a;
        delta_t     delta_minor_b;
        err_t       error_a;
        err_t       error_b;
        logic [2:0] step_signs;
        axis_t      drive_axis;
        logic       active;
    } line_state_t;

endpackage

`default_nettype wire

FILE: rtl/lr3_step.sv
// Combinational line step: from one command word and the current line state
// it forms the next line state and the point word. Depends on lr3_pkg.
`default_nettype none

module lr3_step (
    input  lr3_pkg::cmd_word_t   cmd,
    input  lr3_pkg::line_state_t state,
    output lr3_pkg::line_state_t state_next,
    output lr3_pkg::pnt_word_t   result
);
    import lr3_pkg::*;

    function automatic err_t twice(input delta_t d);
        return err_t'({d, 1'b0});
    endfunction

    function automatic coord_t bump(input coord_t c, input logic neg);
        return neg ? coord_t'(c - coord_t'(1)) : coord_t'(c + coord_t'(1));
    endfunction

    function automatic delta_t magnitude(input logic signed [DELTA_BITS-1:0] d);
        return d[DELTA_BITS-1] ? delta_t'(-d) : delta_t'(d);
    endfunction

    // Start path
    logic signed [DELTA_BITS-1:0] dif_x, dif_y, dif_z;
    delta_t     abs_x, abs_y, abs_z;
    delta_t     new_major, new_minor_a, new_minor_b;
    axis_t      new_axis;
    coord_t     new_end;
    logic [2:0] new_signs;

    // Advance path
    logic   ea_ge, eb_ge;
    logic   step_x, step_y, step_z;
    coord_t adv_x, adv_y, adv_z, adv_major;
    err_t   adv_error_a, adv_error_b;

    assign dif_x = DELTA_BITS'(cmd.end_x) - DELTA_BITS'(cmd.start_x);
    assign dif_y = DELTA_BITS'(cmd.end_y) - DELTA_BITS'(cmd.start_y);
    assign dif_z = DELTA_BITS'(cmd.end_z) - DELTA_BITS'(cmd.start_z);
    assign abs_x = magnitude(dif_x);
    assign abs_y = magnitude(dif_y);
    assign abs_z = magnitude(dif_z);

    // The end at or below the start means a negative step.
    assign new_signs = {dif_z[DELTA_BITS-1] || (dif_z == '0),
                        dif_y[DELTA_BITS-1] || (dif_y == '0),
                        dif_x[DELTA_BITS-1] || (dif_x == '0)};

    always_comb
    begin
        if (abs_x >= abs_y && abs_x >= abs_z)
        begin
            new_axis    = AXIS_X;
            new_end     = cmd.end_x;
            new_major   = abs_x;
            new_minor_a = abs_y;
            new_minor_b = abs_z;
        end
        else if (abs_y >= abs_x && abs_y >= abs_z)
        begin
            new_axis    = AXIS_Y;
            new_end     = cmd.end_y;
            new_major   = abs_y;
            new_minor_a = abs_x;
            new_minor_b = abs_z;
        end
        else
        begin
            new_axis    = AXIS_Z;
            new_end     = cmd.end_z;
            new_major   = abs_z;
            new_minor_a = abs_y;
            new_minor_b = abs_x;
        end
    end

    assign ea_ge = !state.error_a[ERR_BITS-1];
    assign eb_ge = !state.error_b[ERR_BITS-1];

    // Minor a is y for an x or z drive and x for a y drive; minor b is z,
    // except for a z drive where it is x.
    always_comb
    begin
        case (state.drive_axis)
            AXIS_X:
            begin
                step_x = 1'b1;
                step_y = ea_ge;
                step_z = eb_ge;
            end
            AXIS_Y:
            begin
                step_x = ea_ge;
                step_y = 1'b1;
                step_z = eb_ge;
            end
            AXIS_Z:
            begin
                step_x = eb_ge;
                step_y = ea_ge;
                step_z = 1'b1;
            end
            default:
            begin
                step_x = 1'b0;
                step_y = 1'b0;
                step_z = 1'b0;
            end
        endcase
    end

    assign adv_x = step_x ? bump(state.cur_x, state.step_signs[0]) : state.cur_x;
    assign adv_y = step_y ? bump(state.cur_y, state.step_signs[1]) : state.cur_y;
    assign adv_z = step_z ? bump(state.cur_z, state.step_signs[2]) : state.cur_z;

    always_comb
    begin
        case (state.drive_axis)
            AXIS_X:  adv_major = adv_x;
            AXIS_Y:  adv_major = adv_y;
            AXIS_Z:  adv_major = adv_z;
            default: adv_major = adv_x;
        endcase
    end

    assign adv_error_a = state.error_a - (ea_ge ? twice(state.delta_major) : err_t'(0))
                         + twice(state.delta_minor_a);
    assign adv_error_b = state.error_b - (eb_ge ? twice(state.delta_major) : err_t'(0))
                         + twice(state.delta_minor_b);

    always_comb
    begin
        state_next = state;
        result.point_x    = state.cur_x;
        result.point_y    = state.cur_y;
        result.point_z    = state.cur_z;
        result.last_point = 1'b0;
        result.idle       = 1'b0;
        if (cmd.kind == KIND_START)
        begin
            state_next.cur_x         = cmd.start_x;
            state_next.cur_y         = cmd.start_y;
            state_next.cur_z         = cmd.start_z;
            state_next.drive_end     = new_end;
            state_next.delta_major   = new_major;
            state_next.delta_minor_a = new_minor_a;
            state_next.delta_minor_b = new_minor_b;
            state_next.error_a       = twice(new_minor_a) - err_t'(new_major);
            state_next.error_b       = twice(new_minor_b) - err_t'(new_major);
            state_next.step_signs    = new_signs;
            state_next.drive_axis    = new_axis;
            state_next.active        = (new_major != '0);
            result.point_x    = cmd.start_x;
            result.point_y    = cmd.start_y;
            result.point_z    = cmd.start_z;
            result.last_point = (new_major == '0);
        end
        else if (!state.active)
        begin
            result.idle = 1'b1;
        end
        else
        begin
            state_next.cur_x   = adv_x;
            state_next.cur_y   = adv_y;
            state_next.cur_z   = adv_z;
            state_next.error_a = adv_error_a;
            state_next.error_b = adv_error_b;
            state_next.active  = (adv_major != state.drive_end);
            result.point_x    = adv_x;
            result.point_y    = adv_y;
            result.point_z    = adv_z;
            result.last_point = (adv_major == state.drive_end);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/line_raster_3d.sv
// Top level of the 3D line rasteriser: line state register, output register
// and skid register. Depends on lr3_pkg and lr3_step.
`default_nettype none

// A start word loads both endpoints of a line and returns its start point;
// each advance word then returns the next voxel of a 3D Bresenham walk, the
// driving axis being the one of largest extent (x wins ties, then y). The
// word carrying the end point has last_point set; advancing beyond it, or
// before any line was started, repeats the current point with idle set.
// Every command word yields exactly one point word. A word is taken every
// clock while cmd_stall is low: the whole step (delta, axis choice and error
// update) is one pass of adds and compares between the line state register
// and the point register, so one point per cycle is sustained while the
// point side does not stall. The point channel has an output register
// backed by one skid register, so a command is still accepted in the cycle
// in which the point side first stalls; cmd_stall is a register output and
// rises only once both hold data. Coordinates wrap within COORD_BITS.
module line_raster_3d (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_stall,
    input  lr3_pkg::cmd_word_t  cmd,
    output logic                pnt_valid,
    input  wire                 pnt_stall,
    output lr3_pkg::pnt_word_t  pnt
);
    import lr3_pkg::*;

    line_state_t state_reg, state_next;
    pnt_word_t   result;
    pnt_word_t   out_reg, skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    logic        cmd_fire, pnt_fire;

    assign cmd_stall = skid_valid_reg;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign pnt_valid = out_valid_reg;
    assign pnt       = out_reg;
    assign pnt_fire  = out_valid_reg && !pnt_stall;

    lr3_step u_step (
        .cmd        (cmd),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // The line state moves on with every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (cmd_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Output and skid registers. A new point goes to the output register when
    // that is empty or being emptied; otherwise it parks in the skid register,
    // which drains into the output register as soon as the consumer takes one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                if (out_valid_reg && !pnt_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pnt_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && out_valid_reg && !pnt_fire)
        begin
            skid_reg <= result;
        end
        if (cmd_fire && (!out_valid_reg || pnt_fire))
        begin
            out_reg <= result;
        end
        else if (!cmd_fire && pnt_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a point while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && out_valid_reg && pnt_stall) |=> skid_valid_reg)
        else $error("point accepted under output stall was not parked");

    a_idle_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pnt_valid && pnt.idle) |-> !pnt.last_point)
        else $error("idle point marked as line end");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.kind == KIND_ADVANCE && !state_reg.active) |=> $stable(state_reg))
        else $error("advance without a line changed the line state");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && result.last_point) |=> !state_reg.active)
        else $error("line still active after its end point");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the 3D line rasteriser: directed lines, random line walks,
// changing idle patterns on both channels, and a long output hold-off.
// Depends on lr3_pkg and line_raster_3d from the rtl folder; it reads no files.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lr3_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 80;
    localparam int LONG_WALK   = 40;
    localparam int TIME_LIMIT  = 5_000_000;

    // Clock, reset and the two channels.  Every input of the block starts at a
    // known value; the point-side stall is then driven by the checker process.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      pnt_valid;
    logic      pnt_stall = 1'b0;
    pnt_word_t pnt;

    // Idle mix of each side, in cycles per hundred, and the long hold-off flag.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_off      = 1'b0;

    // Points still owed by the block, oldest first.
    pnt_word_t points_due[$];

    // Tallies for the closing summary and the verdict.
    int words_sent   = 0;
    int n_starts     = 0;
    int n_advances   = 0;
    int n_points     = 0;
    int n_last       = 0;
    int n_idle       = 0;
    int stall_cycles = 0;
    int errors       = 0;

    // The bench's own copy of the line state, kept at the block's widths
    // where the block wraps and as plain integers for the error terms.
    coord_t     ln_x, ln_y, ln_z, ln_end;
    int         ln_major, ln_minor_a, ln_minor_b;
    int         ln_err_a, ln_err_b;
    logic [2:0] ln_neg;
    axis_t      ln_axis;
    bit         ln_active;

    line_raster_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pnt_valid (pnt_valid),
        .pnt_stall (pnt_stall),
        .pnt       (pnt)
    );

    always #HALF_PERIOD clk = ~clk;

    // A single unit step of one coordinate; the result wraps within the
    // coordinate width, as the block does.
    function automatic coord_t step_coord(coord_t c, logic neg);
        return neg ? coord_t'(c - 1) : coord_t'(c + 1);
    endfunction

    function automatic int abs_span(coord_t a, coord_t b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // Works out the point that the block must return for one command word and
    // moves the bench's line state on accordingly.
    function automatic pnt_word_t next_point(cmd_word_t w);
        pnt_word_t p;
        int        dx, dy, dz;
        bit        stepped_a, stepped_b;

        p = '0;
        if (w.kind == KIND_START) begin
            dx = abs_span(w.start_x, w.end_x);
            dy = abs_span(w.start_y, w.end_y);
            dz = abs_span(w.start_z, w.end_z);
            // A sign bit is set when the end lies at or below the start.
            ln_neg = {w.end_z <= w.start_z, w.end_y <= w.start_y, w.end_x <= w.start_x};
            ln_x = w.start_x;
            ln_y = w.start_y;
            ln_z = w.start_z;
            // Largest extent drives; x wins ties, then y.
            if (dx >= dy && dx >= dz) begin
                ln_axis = AXIS_X;
                ln_end  = w.end_x;
                ln_major = dx; ln_minor_a = dy; ln_minor_b = dz;
            end
            else if (dy >= dz) begin
                ln_axis = AXIS_Y;
                ln_end  = w.end_y;
                ln_major = dy; ln_minor_a = dx; ln_minor_b = dz;
            end
            else begin
                ln_axis = AXIS_Z;
                ln_end  = w.end_z;
                ln_major = dz; ln_minor_a = dy; ln_minor_b = dx;
            end
            ln_err_a  = 2 * ln_minor_a - ln_major;
            ln_err_b  = 2 * ln_minor_b - ln_major;
            ln_active = (ln_major != 0);
            p.last_point = !ln_active;
        end
        else if (!ln_active) begin
            // Nothing to walk: the current point comes back marked idle.
            p.idle = 1'b1;
        end
        else begin
            stepped_a = (ln_err_a >= 0);
            stepped_b = (ln_err_b >= 0);
            case (ln_axis)
                AXIS_X:
                begin
                    ln_x = step_coord(ln_x, ln_neg[0]);
                    if (stepped_a) ln_y = step_coord(ln_y, ln_neg[1]);
                    if (stepped_b) ln_z = step_coord(ln_z, ln_neg[2]);
                    ln_active = (ln_x != ln_end);
                end
                AXIS_Y:
                begin
                    ln_y = step_coord(ln_y, ln_neg[1]);
                    if (stepped_a) ln_x = step_coord(ln_x, ln_neg[0]);
                    if (stepped_b) ln_z = step_coord(ln_z, ln_neg[2]);
                    ln_active = (ln_y != ln_end);
                end
                default:
                begin
                    ln_z = step_coord(ln_z, ln_neg[2]);
                    if (stepped_a) ln_y = step_coord(ln_y, ln_neg[1]);
                    if (stepped_b) ln_x = step_coord(ln_x, ln_neg[0]);
                    ln_active = (ln_z != ln_end);
                end
            endcase
            if (stepped_a) ln_err_a -= 2 * ln_major;
            if (stepped_b) ln_err_b -= 2 * ln_major;
            ln_err_a += 2 * ln_minor_a;
            ln_err_b += 2 * ln_minor_b;
            p.last_point = !ln_active;
        end
        p.point_x = ln_x;
        p.point_y = ln_y;
        p.point_z = ln_z;
        return p;
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // A coordinate within a dozen steps of c, wrapping at the range ends.
    function automatic coord_t nudge(coord_t c);
        return coord_t'(c + $urandom_range(24) - 12);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offers one word after a random gap, holds it until it is taken, and then
    // records the point that the block owes for it.  The valid line is left
    // high after acceptance so that back-to-back words need no extra drive.
    task automatic send_word(cmd_word_t w);
        pnt_word_t due;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        due = next_point(w);
        points_due.insert(points_due.size(), due);
        words_sent++;
        if (w.kind == KIND_START) n_starts++;
        else n_advances++;
    endtask

    task automatic send_start(coord_t sx, coord_t sy, coord_t sz,
                              coord_t ex, coord_t ey, coord_t ez);
        cmd_word_t w;
        w = '{kind: KIND_START, start_x: sx, start_y: sy, start_z: sz,
              end_x: ex, end_y: ey, end_z: ez};
        send_word(w);
    endtask

    // Endpoint fields of an advance word carry random noise; the block must
    // ignore them.
    task automatic send_advance();
        cmd_word_t w;
        w = '{kind: KIND_ADVANCE, start_x: rand_coord(), start_y: rand_coord(),
              start_z: rand_coord(), end_x: rand_coord(), end_y: rand_coord(),
              end_z: rand_coord()};
        send_word(w);
    endtask

    // Checker: every accepted point is matched against the oldest one owed.
    // The stall for the next cycle is chosen here too, so the point side
    // gets exactly one drive per clock edge.
    always @(posedge clk) begin
        pnt_word_t want;
        if (rst_n && pnt_valid && !pnt_stall) begin
            if (points_due.size() == 0) begin
                $error("point word (%0d,%0d,%0d) arrived with none outstanding",
                       pnt.point_x, pnt.point_y, pnt.point_z);
                errors++;
            end
            else begin
                want = points_due.pop_front();
                check_field("point_x", int'(want.point_x), int'(pnt.point_x));
                check_field("point_y", int'(want.point_y), int'(pnt.point_y));
                check_field("point_z", int'(want.point_z), int'(pnt.point_z));
                check_field("last_point", int'(want.last_point), int'(pnt.last_point));
                check_field("idle", int'(want.idle), int'(pnt.idle));
                n_points++;
                n_last += pnt.last_point;
                n_idle += pnt.idle;
            end
        end
        if (rst_n && cmd_stall) stall_cycles++;
        pnt_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Hand-picked lines: the reset point, degenerate and extreme lines, each
    // driving axis with its tie-breaks, both step directions, walking past the
    // end, and a new line started on top of a live one.
    task automatic test_directed();
        // Advance straight after reset repeats the origin as idle.
        send_advance();
        // Degenerate line at the corner of the range; then nothing is active.
        send_start(-12'sd2048, 12'sd2047, 12'sd0, -12'sd2048, 12'sd2047, 12'sd0);
        send_advance();
        // Three-way tie goes to x; one advance beyond the end.
        send_start(12'sd0, 12'sd0, 12'sd0, 12'sd3, 12'sd3, 12'sd3);
        repeat (4) send_advance();
        // y and z tie with x flat: y drives, z and x step negative.
        send_start(12'sd5, -12'sd1, 12'sd7, 12'sd5, 12'sd2, 12'sd4);
        repeat (4) send_advance();
        // z drives near the top of x; abandoned half way by the next start.
        send_start(12'sd2047, -12'sd2048, -12'sd2048, 12'sd2045, -12'sd2047, -12'sd2044);
        repeat (2) send_advance();
        // Longest possible line, corner to corner, all extents equal.
        send_start(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047, -12'sd2048);
        repeat (3) send_advance();
        // Short line walked downwards on every axis, then cut short.
        send_start(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2043, 12'sd2045, 12'sd2046);
        repeat (2) send_advance();
    endtask

    // Random line walks.  Most are whole lines with up to two steps beyond the
    // end; some are broken off early, and a few words are pure noise.
    task automatic test_random_lines(int n_words, int send_pct, int recv_pct);
        int     target;
        int     roll;
        int     shape;
        int     steps;
        coord_t sx, sy, sz, ex, ey, ez;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = words_sent + n_words;
        while (words_sent < target) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                if ($urandom_range(1)) send_advance();
                else send_start(rand_coord(), rand_coord(), rand_coord(),
                                rand_coord(), rand_coord(), rand_coord());
            end
            else begin
                sx = rand_coord();
                sy = rand_coord();
                sz = rand_coord();
                shape = $urandom_range(99);
                if (shape < 80) begin
                    ex = nudge(sx); ey = nudge(sy); ez = nudge(sz);
                end
                else if (shape < 95) begin
                    ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
                end
                else begin
                    ex = sx; ey = sy; ez = sz;
                end
                send_start(sx, sy, sz, ex, ey, ez);
                steps = ln_active ? ln_major : 0;
                if (steps > LONG_WALK) steps = $urandom_range(LONG_WALK);
                if (roll < 15) steps = $urandom_range(steps);
                else steps += $urandom_range(2);
                repeat (steps) send_advance();
            end
        end
    endtask

    // The point side holds off for a long stretch while words keep coming, so
    // the output and skid registers fill and the block stalls its input.
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        send_start(-12'sd100, 12'sd50, 12'sd7, 12'sd100, -12'sd30, 12'sd0);
        repeat (60) send_advance();
    endtask

    // Main sequence: reset once, then the tests under the three idle mixes.
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 47;
        test_directed();
        test_random_lines(500, 12, 47);
        test_random_lines(500, 47, 12);
        test_random_lines(400, 0, 0);
        test_output_hold();

        cmd_valid <= 1'b0;
        while (points_due.size() != 0) @(posedge clk);
        // Wait on after the queue empties, so that any stray point is caught.
        repeat (4) @(posedge clk);
        if (points_due.size() != 0) begin
            $error("%0d point words never arrived", points_due.size());
            errors++;
        end

        $display("Run covered %0d line starts and %0d advances; %0d points checked,",
                 n_starts, n_advances, n_points);
        $display("%0d line ends, %0d idle repeats; input stall seen for %0d cycles.",
                 n_last, n_idle, stall_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #TIME_LIMIT;
        $display("FAIL");
        $finish;
    end

endmodule
